// File: design/crcfc_pkg.sv
// Package for the CRC frame checker: defaults, header offsets, status and
// register codes, and the CRC32C byte update. No dependencies.
package crcfc_pkg;

	localparam int HEADER_BYTES_DEF  = 40;
	localparam int SLOT_TOTAL_DEF    = 8;
	localparam int PAYLOAD_LIMIT_DEF = 4096;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int OFS_VERSION   = 4;
	localparam int OFS_HLEN      = 6;
	localparam int OFS_HLEN_END  = 8;
	localparam int OFS_PLEN      = 12;
	localparam int OFS_PLEN_END  = 16;
	localparam int OFS_PCRC      = 32;
	localparam int OFS_HCRC      = 36;
	localparam int OFS_HCRC_END  = 40;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [12:0] MAX_PAYLOAD_RST = 13'd4096;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_MAGIC,
		ST_VERSION,
		ST_RANGE,
		ST_CRC
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC,
		CFG_VERSION,
		CFG_MAX_PAYLOAD
	} cfg_index_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: design/crcfc_byte_if.sv
// Byte stream channel into the frame checker: valid/ready with one frame byte
// and its last-byte mark. No dependencies.
interface crcfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// File: design/crcfc_result_if.sv
// Result channel out of the frame checker: valid/ready with the frame status
// and running counters. Depends on crcfc_pkg.
interface crcfc_result_if;
	import crcfc_pkg::*;
	logic        valid;
	logic        ready;
	status_t     status;
	logic [2:0]  slot_index;
	logic [3:0]  live_count;
	logic [31:0] accepted_count;
	logic [31:0] rejected_count;
	logic [31:0] payload_check;
	logic [63:0] sequence_number;

	modport source (output valid, status, slot_index, live_count, accepted_count,
		rejected_count, payload_check, sequence_number, input ready);
	modport sink   (input valid, status, slot_index, live_count, accepted_count,
		rejected_count, payload_check, sequence_number, output ready);
endinterface

// File: design/crcfc_cfg_if.sv
// Register write channel of the frame checker: valid/ready with register
// index and write data. Depends on crcfc_pkg.
interface crcfc_cfg_if;
	import crcfc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/crc_frame_checker.sv
// CRC frame checker: one byte per cycle, header CRC32C and payload CRC32C,
// status and counters reported on the last byte of each frame.
// The last byte is taken into the input register, and the result register loads
// as that byte leaves it. Throughput: one byte per cycle while no last byte waits.
// The result register holds while stalled; only a last byte waits on it.
// Reset (arst_n low, asynchronous) clears all frame state and counters.
module crc_frame_checker #(
	parameter int HEADER_BYTES  = crcfc_pkg::HEADER_BYTES_DEF,
	parameter int SLOT_TOTAL    = crcfc_pkg::SLOT_TOTAL_DEF,
	parameter int PAYLOAD_LIMIT = crcfc_pkg::PAYLOAD_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	crcfc_byte_if.sink     frame,
	crcfc_result_if.source result,
	crcfc_cfg_if.sink      cfg
);
	import crcfc_pkg::*;

	localparam int POS_CAP = HEADER_BYTES + PAYLOAD_LIMIT + 1;
	localparam int POS_W   = $clog2(POS_CAP + 1);
	localparam int SLOT_W  = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
	localparam int FILL_W  = $clog2(SLOT_TOTAL + 1);

	localparam logic [POS_W-1:0] P_CAP      = POS_W'(POS_CAP);
	localparam logic [POS_W-1:0] P_PAY_END  = POS_W'(POS_CAP - 1);
	localparam logic [POS_W-1:0] P_HDR      = POS_W'(HEADER_BYTES);
	localparam logic [POS_W-1:0] P_VER      = POS_W'(OFS_VERSION);
	localparam logic [POS_W-1:0] P_HLEN     = POS_W'(OFS_HLEN);
	localparam logic [POS_W-1:0] P_HLEN_END = POS_W'(OFS_HLEN_END);
	localparam logic [POS_W-1:0] P_PLEN     = POS_W'(OFS_PLEN);
	localparam logic [POS_W-1:0] P_PLEN_END = POS_W'(OFS_PLEN_END);
	localparam logic [POS_W-1:0] P_PCRC     = POS_W'(OFS_PCRC);
	localparam logic [POS_W-1:0] P_HCRC     = POS_W'(OFS_HCRC);
	localparam logic [POS_W-1:0] P_HCRC_END = POS_W'(OFS_HCRC_END);

	logic [31:0] magic_cfg_q;
	logic [15:0] version_cfg_q;
	logic [12:0] max_pl_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [POS_W-1:0] pos_q;
	logic [31:0] magic_q, plen_q, pcrc_stored_q, hcrc_stored_q, hcrc_q, pcrc_q;
	logic [15:0] version_q, hlen_q;
	logic [31:0] accepted_q, rejected_q, good_crc_q;
	logic [SLOT_W-1:0] ring_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0] seq_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [SLOT_W-1:0] slot_q;

	logic [POS_W-1:0] total;
	logic [31:0] magic_n, plen_n, pcrc_stored_n, hcrc_stored_n, hcrc_n, pcrc_n;
	logic [15:0] version_n, hlen_n;
	logic [7:0]  hbyte;
	status_t     status_n;
	logic        advance, emit, ok;
	logic [SLOT_W:0] ring_inc;
	logic [SLOT_W-1:0] ring_n;

	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign emit        = advance && last_s1;
	assign ok          = (status_n == ST_OK);
	assign frame.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	always_comb begin
		magic_n       = magic_q;
		version_n     = version_q;
		hlen_n        = hlen_q;
		plen_n        = plen_q;
		pcrc_stored_n = pcrc_stored_q;
		hcrc_stored_n = hcrc_stored_q;
		hcrc_n        = hcrc_q;
		pcrc_n        = pcrc_q;
		hbyte         = byte_s1;
		total         = P_CAP;
		if (pos_q < P_CAP) begin
			if (pos_q < P_HDR) begin
				if (pos_q >= P_HCRC && pos_q < P_HCRC_END) begin
					hbyte = 8'h00;
				end
				hcrc_n = crc32c_byte(hcrc_q, hbyte);
				if (pos_q < P_VER) begin
					magic_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
				end else if (pos_q < P_HLEN) begin
					version_n[{pos_q[0], 3'b000} +: 8] = byte_s1;
				end else if (pos_q < P_HLEN_END) begin
					hlen_n[{pos_q[0], 3'b000} +: 8] = byte_s1;
				end else if (pos_q >= P_PLEN && pos_q < P_PLEN_END) begin
					plen_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
				end else if (pos_q >= P_PCRC && pos_q < P_HCRC) begin
					pcrc_stored_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
				end else if (pos_q >= P_HCRC && pos_q < P_HCRC_END) begin
					hcrc_stored_n[{pos_q[1:0], 3'b000} +: 8] = byte_s1;
				end
			end else if (pos_q < P_PAY_END) begin
				pcrc_n = crc32c_byte(pcrc_q, byte_s1);
			end
			total = pos_q + POS_W'(1);
		end
	end

	always_comb begin
		if (total < P_HDR) begin
			status_n = ST_SHORT;
		end else if (magic_n != magic_cfg_q) begin
			status_n = ST_MAGIC;
		end else if (version_n != version_cfg_q || hlen_n != 16'(HEADER_BYTES)) begin
			status_n = ST_VERSION;
		end else if (plen_n > {19'h0, max_pl_q} || plen_n > 32'(PAYLOAD_LIMIT) ||
				({1'b0, plen_n} + 33'(HEADER_BYTES)) != 33'(total)) begin
			status_n = ST_RANGE;
		end else if ((~hcrc_n) != hcrc_stored_n || (~pcrc_n) != pcrc_stored_n) begin
			status_n = ST_CRC;
		end else begin
			status_n = ST_OK;
		end
	end

	always_comb begin
		ring_inc = {1'b0, ring_q} + (SLOT_W + 1)'(1);
		if (ring_inc >= (SLOT_W + 1)'(SLOT_TOTAL)) begin
			ring_n = '0;
		end else begin
			ring_n = ring_inc[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_cfg_q   <= '0;
			version_cfg_q <= '0;
			max_pl_q      <= MAX_PAYLOAD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MAGIC:       magic_cfg_q   <= cfg.data;
				CFG_VERSION:     version_cfg_q <= cfg.data[15:0];
				CFG_MAX_PAYLOAD: max_pl_q      <= cfg.data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.frame_byte;
			last_s1 <= frame.last_byte;
		end
		if (emit) begin
			status_q <= status_n;
			slot_q   <= ring_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			magic_q       <= '0;
			version_q     <= '0;
			hlen_q        <= '0;
			plen_q        <= '0;
			pcrc_stored_q <= '0;
			hcrc_stored_q <= '0;
			hcrc_q        <= CRC_INIT;
			pcrc_q        <= CRC_INIT;
			accepted_q    <= '0;
			rejected_q    <= '0;
			good_crc_q    <= '0;
			ring_q        <= '0;
			fill_q        <= '0;
			seq_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				pos_q         <= '0;
				magic_q       <= '0;
				version_q     <= '0;
				hlen_q        <= '0;
				plen_q        <= '0;
				pcrc_stored_q <= '0;
				hcrc_stored_q <= '0;
				hcrc_q        <= CRC_INIT;
				pcrc_q        <= CRC_INIT;
				if (ok) begin
					good_crc_q <= pcrc_stored_n;
					accepted_q <= accepted_q + 32'd1;
					ring_q     <= ring_n;
					seq_q      <= seq_q + 64'd1;
					if (fill_q < FILL_W'(SLOT_TOTAL)) begin
						fill_q <= fill_q + FILL_W'(1);
					end
				end else begin
					rejected_q <= rejected_q + 32'd1;
				end
			end else if (advance) begin
				pos_q         <= total;
				magic_q       <= magic_n;
				version_q     <= version_n;
				hlen_q        <= hlen_n;
				plen_q        <= plen_n;
				pcrc_stored_q <= pcrc_stored_n;
				hcrc_stored_q <= hcrc_stored_n;
				hcrc_q        <= hcrc_n;
				pcrc_q        <= pcrc_n;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = status_q;
	assign result.slot_index      = 3'(slot_q);
	assign result.live_count      = 4'(fill_q);
	assign result.accepted_count  = accepted_q;
	assign result.rejected_count  = rejected_q;
	assign result.payload_check   = good_crc_q;
	assign result.sequence_number = seq_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SLOT_TOTAL))
		else $error("live count beyond ring size");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= P_CAP)
		else $error("byte position beyond saturation point");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !result.ready) |-> !frame.ready)
		else $error("byte accepted while last byte waits on result register");

	a_accept_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && ok) |=> (accepted_q == $past(accepted_q) + 32'd1 &&
			rejected_q == $past(rejected_q)))
		else $error("accepted frame did not advance counters");
`endif

endmodule

// File: dv/crcfc_tb_pkg.sv
`timescale 1ns / 1ps
// Testbench constants for the CRC frame checker: header layout, byte counter
// cap and a bit-serial CRC32C step. Depends on crcfc_pkg.
package crcfc_tb_pkg;

	localparam int HDR_LEN    = crcfc_pkg::HEADER_BYTES_DEF;
	localparam int RING_SLOTS = crcfc_pkg::SLOT_TOTAL_DEF;
	localparam int PLEN_CAP   = crcfc_pkg::PAYLOAD_LIMIT_DEF;
	localparam int POS_LIMIT  = HDR_LEN + PLEN_CAP + 1;

	localparam int AT_MAGIC = 0;
	localparam int AT_VER   = 4;
	localparam int AT_HLEN  = 6;
	localparam int AT_PLEN  = 12;
	localparam int AT_PCRC  = 32;
	localparam int AT_HCRC  = 36;

	localparam logic [31:0] CRC32C_REFLECTED = 32'h82F6_3B78;
	localparam logic [31:0] CRC_SEED         = 32'hFFFF_FFFF;

	function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = acc[0] ^ b[i];
			acc = acc >> 1;
			if (fb) begin
				acc = acc ^ CRC32C_REFLECTED;
			end
		end
		return acc;
	endfunction

endpackage

// File: dv/crcfc_report_checker.sv
`timescale 1ns / 1ps
// Frame report checker: watches the byte, result and register channels, predicts
// each frame report and compares it field by field. Depends on crcfc_pkg,
// crcfc_tb_pkg and the three channel interfaces.
module crcfc_report_checker (
	input  logic    clk,
	input  logic    arst_n,
	crcfc_byte_if   frame,
	crcfc_result_if result,
	crcfc_cfg_if    cfg,
	output int      fail_count,
	output int      pending
);
	import crcfc_pkg::*;
	import crcfc_tb_pkg::*;

	typedef struct {
		status_t     status;
		logic [2:0]  slot;
		logic [3:0]  live;
		logic [31:0] accepted;
		logic [31:0] rejected;
		logic [31:0] good_crc;
		logic [63:0] seq;
	} frame_report_t;

	frame_report_t frame_reports_q[$];

	logic [31:0] want_magic;
	logic [15:0] want_version;
	logic [12:0] payload_max;

	int unsigned byte_pos;
	logic [31:0] hdr_magic;
	logic [15:0] hdr_version;
	logic [15:0] hdr_length;
	logic [31:0] hdr_plen;
	logic [31:0] hdr_pcrc;
	logic [31:0] hdr_hcrc;
	logic [31:0] hcrc_acc;
	logic [31:0] pcrc_acc;
	logic [31:0] accepted_frames;
	logic [31:0] rejected_frames;
	logic [31:0] good_payload_crc;
	logic [2:0]  next_slot;
	logic [3:0]  filled_ring;
	logic [63:0] accept_seq;

	task automatic restart_frame();
		byte_pos = 0;
		hdr_magic = '0;
		hdr_version = '0;
		hdr_length = '0;
		hdr_plen = '0;
		hdr_pcrc = '0;
		hdr_hcrc = '0;
		hcrc_acc = CRC_SEED;
		pcrc_acc = CRC_SEED;
	endtask

	task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
		if (fail_count < 100) begin
			$display("ERROR at %0t: frame report %s: got %0h, want %0h", $time, what, got, want);
		end
		fail_count++;
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		case (idx)
			CFG_MAGIC: want_magic = value;
			CFG_VERSION: want_version = value[15:0];
			CFG_MAX_PAYLOAD: payload_max = value[12:0];
			default: ;
		endcase
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic last);
		int unsigned pos;
		int unsigned total;
		logic [31:0] frame_end;
		status_t st;
		frame_report_t rep;
		pos = byte_pos;
		if (pos < POS_LIMIT) begin
			if (pos < HDR_LEN) begin
				hcrc_acc = crc32c_step(hcrc_acc, (pos >= AT_HCRC) ? 8'h00 : b);
				if (pos < AT_VER) begin
					hdr_magic[8*pos +: 8] = b;
				end else if (pos < AT_HLEN) begin
					hdr_version[8*(pos-AT_VER) +: 8] = b;
				end else if (pos < AT_HLEN + 2) begin
					hdr_length[8*(pos-AT_HLEN) +: 8] = b;
				end else if (pos >= AT_PLEN && pos < AT_PLEN + 4) begin
					hdr_plen[8*(pos-AT_PLEN) +: 8] = b;
				end else if (pos >= AT_PCRC && pos < AT_PCRC + 4) begin
					hdr_pcrc[8*(pos-AT_PCRC) +: 8] = b;
				end else if (pos >= AT_HCRC) begin
					hdr_hcrc[8*(pos-AT_HCRC) +: 8] = b;
				end
			end else if (pos < POS_LIMIT - 1) begin
				pcrc_acc = crc32c_step(pcrc_acc, b);
			end
			total = pos + 1;
		end else begin
			total = POS_LIMIT;
		end
		if (!last) begin
			byte_pos = total;
			return;
		end
		frame_end = 32'(HDR_LEN) + hdr_plen;
		if (total < HDR_LEN) begin
			st = ST_SHORT;
		end else if (hdr_magic != want_magic) begin
			st = ST_MAGIC;
		end else if (hdr_version != want_version || hdr_length != 16'(HDR_LEN)) begin
			st = ST_VERSION;
		end else if (hdr_plen > 32'(payload_max) || hdr_plen > 32'(PLEN_CAP)
				|| 32'(total) != frame_end) begin
			st = ST_RANGE;
		end else if (~hcrc_acc != hdr_hcrc || ~pcrc_acc != hdr_pcrc) begin
			st = ST_CRC;
		end else begin
			st = ST_OK;
		end
		rep.slot = next_slot;
		if (st == ST_OK) begin
			good_payload_crc = hdr_pcrc;
			accepted_frames++;
			next_slot = (int'(next_slot) + 1 >= RING_SLOTS) ? 3'd0 : next_slot + 3'd1;
			if (filled_ring < 4'(RING_SLOTS)) begin
				filled_ring++;
			end
			accept_seq++;
		end else begin
			rejected_frames++;
		end
		restart_frame();
		rep.status = st;
		rep.live = filled_ring;
		rep.accepted = accepted_frames;
		rep.rejected = rejected_frames;
		rep.good_crc = good_payload_crc;
		rep.seq = accept_seq;
		frame_reports_q.push_back(rep);
	endtask

	task automatic check_report();
		frame_report_t want;
		if (frame_reports_q.size() == 0) begin
			flag("with none waiting, status", 64'(result.status), 64'(0));
			return;
		end
		want = frame_reports_q.pop_front();
		if (result.status !== want.status)
			flag("status", 64'(result.status), 64'(want.status));
		if (result.slot_index !== want.slot)
			flag("slot_index", 64'(result.slot_index), 64'(want.slot));
		if (result.live_count !== want.live)
			flag("live_count", 64'(result.live_count), 64'(want.live));
		if (result.accepted_count !== want.accepted)
			flag("accepted_count", 64'(result.accepted_count), 64'(want.accepted));
		if (result.rejected_count !== want.rejected)
			flag("rejected_count", 64'(result.rejected_count), 64'(want.rejected));
		if (result.payload_check !== want.good_crc)
			flag("payload_check", 64'(result.payload_check), 64'(want.good_crc));
		if (result.sequence_number !== want.seq)
			flag("sequence_number", result.sequence_number, want.seq);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			frame_reports_q.delete();
			want_magic = '0;
			want_version = '0;
			payload_max = MAX_PAYLOAD_RST;
			restart_frame();
			accepted_frames = '0;
			rejected_frames = '0;
			good_payload_crc = '0;
			next_slot = '0;
			filled_ring = '0;
			accept_seq = '0;
			pending = 0;
		end else begin
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				check_report();
			end
			if (cfg.valid && cfg.ready === 1'b1) begin
				apply_write(cfg.index, cfg.data);
			end
			if (frame.valid && frame.ready === 1'b1) begin
				predict_byte(frame.frame_byte, frame.last_byte);
			end
			pending = frame_reports_q.size();
		end
	end

endmodule

// File: dv/tb_crc_frame_checker.sv
`timescale 1ns / 1ps
// Top of the CRC frame checker testbench: clock, reset, frame and register
// stimulus, result back-pressure and the verdict. Depends on crcfc_pkg,
// crcfc_tb_pkg, the channel interfaces and crcfc_report_checker.
module tb_crc_frame_checker;
	import crcfc_pkg::*;
	import crcfc_tb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	bit   hold_req;
	int   fail_count;
	int   pending;
	int   bytes_sent;
	int   frames_sent;

	logic [31:0] cur_magic;
	logic [15:0] cur_version;
	logic [12:0] cur_max;
	logic [7:0]  frame_buf[$];

	crcfc_byte_if   frame_ch();
	crcfc_result_if result_ch();
	crcfc_cfg_if    cfg_ch();

	crc_frame_checker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	crcfc_report_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("crc_frame_checker: mismatch");
		$finish;
	end

	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.frame_byte <= b;
		frame_ch.last_byte <= last;
		@(posedge clk);
		while (!frame_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++) begin
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
		frames_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_MAGIC: cur_magic = value;
			CFG_VERSION: cur_version = value[15:0];
			CFG_MAX_PAYLOAD: cur_max = value[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drop valid, then wait until every frame report is back and the pipe is empty
	task automatic settle();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_le(input int at, input logic [31:0] w, input int n);
		for (int k = 0; k < n; k++) begin
			frame_buf[at + k] = w[8*k +: 8];
		end
	endtask

	task automatic build_frame(input logic [31:0] magic, input logic [15:0] ver,
			input logic [15:0] hlen, input logic [31:0] plen, input int body_len,
			input bit bad_hcrc, input bit bad_pcrc);
		logic [31:0] acc;
		logic [7:0]  b;
		frame_buf.delete();
		for (int i = 0; i < HDR_LEN; i++) begin
			frame_buf.push_back(8'($urandom_range(255)));
		end
		put_le(AT_MAGIC, magic, 4);
		put_le(AT_VER, 32'(ver), 2);
		put_le(AT_HLEN, 32'(hlen), 2);
		put_le(AT_PLEN, plen, 4);
		acc = CRC_SEED;
		for (int i = 0; i < body_len; i++) begin
			b = 8'($urandom_range(255));
			frame_buf.push_back(b);
			acc = crc32c_step(acc, b);
		end
		acc = ~acc;
		if (bad_pcrc) begin
			acc[$urandom_range(31)] ^= 1'b1;
		end
		put_le(AT_PCRC, acc, 4);
		acc = CRC_SEED;
		for (int i = 0; i < HDR_LEN; i++) begin
			acc = crc32c_step(acc, (i >= AT_HCRC) ? 8'h00 : frame_buf[i]);
		end
		acc = ~acc;
		if (bad_hcrc) begin
			acc[$urandom_range(31)] ^= 1'b1;
		end
		put_le(AT_HCRC, acc, 4);
	endtask

	task automatic good_frame(input int body_len);
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(body_len), body_len, 0, 0);
		send_frame();
	endtask

	task automatic cut_frame(input int keep);
		while (frame_buf.size() > keep) begin
			void'(frame_buf.pop_back());
		end
	endtask

	task automatic random_frame();
		int pick;
		int body;
		int n;
		logic [31:0] plen;
		pick = $urandom_range(99);
		body = $urandom_range(12);
		if (pick < 55) begin
			build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(body), body, 0, 0);
		end else if (pick < 64) begin
			build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(body), body, 1, 0);
		end else if (pick < 71) begin
			build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(body), body, 0, 1);
		end else if (pick < 76) begin
			build_frame(cur_magic ^ (32'd1 << $urandom_range(31)), cur_version,
				16'(HDR_LEN), 32'(body), body, $urandom_range(1), 0);
		end else if (pick < 81) begin
			build_frame(cur_magic, cur_version ^ (16'd1 << $urandom_range(15)),
				16'(HDR_LEN), 32'(body), body, 0, $urandom_range(1));
		end else if (pick < 84) begin
			build_frame(cur_magic, cur_version, 16'(HDR_LEN) ^ (16'd1 << $urandom_range(15)),
				32'(body), body, 0, 0);
		end else if (pick < 88) begin
			n = (body > 0 && $urandom_range(1)) ? body - 1 : body + 1 + $urandom_range(2);
			build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(body), n, 0, 0);
		end else if (pick < 92) begin
			plen = 32'(cur_max) + 32'd1 + 32'($urandom_range(3));
			n = (plen <= 32'd16) ? int'(plen) : body;
			build_frame(cur_magic, cur_version, 16'(HDR_LEN), plen, n, 0, 0);
		end else if (pick < 96) begin
			build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(body), body, 0, 0);
			cut_frame($urandom_range(1, HDR_LEN + body - 1));
		end else begin
			n = $urandom_range(1, 60);
			frame_buf.delete();
			for (int i = 0; i < n; i++) begin
				frame_buf.push_back(8'($urandom_range(255)));
			end
		end
		send_frame();
	endtask

	task automatic random_run(input int byte_goal, input int frame_goal);
		int byte_stop;
		int frame_stop;
		byte_stop = bytes_sent + byte_goal;
		frame_stop = frames_sent + frame_goal;
		while (bytes_sent < byte_stop || frames_sent < frame_stop) begin
			random_frame();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		frame_ch.valid <= 1'b0;
		frame_ch.frame_byte <= '0;
		frame_ch.last_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		send_idle = 21;
		recv_idle = 83;
		hold_req = 1'b0;
		bytes_sent = 0;
		frames_sent = 0;
		cur_magic = '0;
		cur_version = '0;
		cur_max = MAX_PAYLOAD_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		good_frame(0);
		good_frame(1);
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'd0, 0, 0, 0);
		cut_frame(1);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'd0, 0, 0, 0);
		cut_frame(HDR_LEN - 1);
		send_frame();
		build_frame(cur_magic ^ 32'h8000_0001, cur_version, 16'(HDR_LEN), 32'd2, 2, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version ^ 16'h8001, 16'(HDR_LEN), 32'd2, 2, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN + 1), 32'd2, 2, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'hFFFF, 32'd0, 0, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(PLEN_CAP + 1), 0, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'hFFFF_FFFF, 0, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'd5, 4, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'd5, 6, 0, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'd3, 3, 1, 0);
		send_frame();
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'd3, 3, 0, 1);
		send_frame();
		build_frame(~cur_magic, ~cur_version, 16'd0, 32'hFFFF_FFFF, 1, 1, 1);
		send_frame();
		good_frame(PLEN_CAP);
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(PLEN_CAP), POS_LIMIT + 60, 0, 0);
		send_frame();
		repeat (RING_SLOTS + 1) good_frame($urandom_range(3));
		settle();

		write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
		write_reg(CFG_VERSION, 32'h0000_FFFF);
		write_reg(CFG_MAX_PAYLOAD, {19'($urandom), 13'd0});
		write_reg(CFG_SPARE, $urandom);
		good_frame(0);
		random_run(420, 20);
		settle();

		send_idle = 83;
		recv_idle = 21;
		write_reg(CFG_MAGIC, $urandom);
		write_reg(CFG_VERSION, $urandom);
		write_reg(CFG_MAX_PAYLOAD, {19'($urandom), 13'd20});
		random_run(420, 20);
		settle();

		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_MAGIC, 32'h0000_0000);
		write_reg(CFG_VERSION, 32'h0000_0000);
		write_reg(CFG_MAX_PAYLOAD, 32'h0000_1FFF);
		build_frame(cur_magic, cur_version, 16'(HDR_LEN), 32'(PLEN_CAP + 1), 0, 0, 0);
		send_frame();
		good_frame(5);
		settle();
		write_reg(CFG_MAX_PAYLOAD, {19'($urandom), 13'(PLEN_CAP)});
		// hold the receiver off while one-byte frames back up the block
		hold_req = 1'b1;
		repeat (12) begin
			send_byte(8'($urandom_range(255)), 1'b1);
			frames_sent++;
		end
		random_run(420, 20);
		settle();

		if (fail_count == 0) begin
			$display("crc_frame_checker: match");
		end else begin
			$display("crc_frame_checker: mismatch");
		end
		$finish;
	end

endmodule
